/* rtl/core/wbss_pkg.sv */
// Package for the wildcard byte signature scanner.
// Holds shared constants, register index codes and the signature bundle type.
// No dependencies.
`default_nettype none

package wbss_pkg;

    // Default parameter values.
    localparam int MAX_SIG_LEN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // Signature slots that are configurable; positions beyond are zero, never wild.
    localparam int SIG_SLOTS = 16;
    localparam int SLOT_W    = 4;

    // Fixed field widths.
    localparam int BYTE_W    = 8;
    localparam int OUT_OFF_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;
    localparam int SIG_LEN_W = 5;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIG_LOW   = 2'd0,
        CFG_SIG_HIGH  = 2'd1,
        CFG_WILD_MASK = 2'd2,
        CFG_SIG_LEN   = 2'd3
    } cfg_idx_t;

    // Signature bytes and wildcard bits handed to every cell.
    typedef struct packed {
        logic [SIG_SLOTS-1:0][BYTE_W-1:0] bytes;
        logic [SIG_SLOTS-1:0]             wild;
    } sig_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/wbss_cell.sv */
// One window cell of the signature scanner: holds one recent image byte,
// passes it to its neighbor on each shift and compares it to its signature byte.
// Depends on wbss_pkg.
`default_nettype none

module wbss_cell #(
    parameter int IDX         = 0,
    parameter int MAX_SIG_LEN = wbss_pkg::MAX_SIG_LEN_DEF,
    localparam int LEN_W      = $clog2(MAX_SIG_LEN + 1)
) (
    input  wire logic                    aclk,
    input  wire logic                    shift_en,
    input  wire logic [7:0]              win_in,
    input  wire wbss_pkg::sig_cfg_t      sig_cfg,
    input  wire logic [LEN_W-1:0]        used_len,
    output logic [7:0]                   win_out,
    output logic                         match
);
    import wbss_pkg::*;

    logic [BYTE_W-1:0] data_reg;
    logic [LEN_W-1:0]  sig_pos;
    logic [SLOT_W-1:0] slot;
    logic              in_use;
    logic              ref_wild;
    logic [BYTE_W-1:0] ref_byte;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= win_in;
        end
    end

    // Cell IDX holds the byte received IDX items ago; it lines up with
    // signature position used_len - 1 - IDX.
    always_comb begin
        in_use   = LEN_W'(IDX) < used_len;
        sig_pos  = used_len - LEN_W'(1) - LEN_W'(IDX);
        slot     = SLOT_W'(sig_pos);
        ref_byte = '0;
        ref_wild = 1'b0;
        if (int'(sig_pos) < SIG_SLOTS) begin
            ref_byte = sig_cfg.bytes[slot];
            ref_wild = sig_cfg.wild[slot];
        end
        match = !in_use || ref_wild || (data_reg == ref_byte);
    end

    assign win_out = data_reg;

endmodule

`default_nettype wire

/* rtl/core/wildcard_byte_signature_scan_top.sv */
// A result item is offered on m_tvalid once the image byte that completes the
// match or ends the image has passed stage one and the output register.
// Throughput: one image byte per cycle while m_tready stays high; the row of
// window cells shifts once per accepted item and all compare in parallel.
// Reset (aresetn low, synchronous) clears the byte count, the reported flag,
// the pipeline and output valids, and sets the signature length to one.
`default_nettype none

module wildcard_byte_signature_scan_top #(
    parameter int MAX_SIG_LEN = wbss_pkg::MAX_SIG_LEN_DEF,
    parameter int OFFSET_BITS = wbss_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write channel.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wbss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wbss_pkg::CFG_DAT_W-1:0] cfg_data,
    // Image stream in.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] image_byte
    input  wire logic                           s_tlast,   // image_last
    // Result stream out.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [wbss_pkg::OUT_OFF_W-1:0]      m_tdata,   // [31:0] match_offset
    output logic                                m_tuser    // match_found
);
    import wbss_pkg::*;

    localparam int LEN_W = $clog2(MAX_SIG_LEN + 1);

    // Configuration registers. They must only be written while the scanner is idle,
    // so no item in flight sees a change; the block itself does not enforce it.
    logic [CFG_DAT_W-1:0] sig_low_reg;
    logic [CFG_DAT_W-1:0] sig_high_reg;
    logic [SIG_SLOTS-1:0] wild_reg;
    logic [SIG_LEN_W-1:0] len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_low_reg  <= '0;
            sig_high_reg <= '0;
            wild_reg     <= '0;
            len_reg      <= SIG_LEN_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SIG_LOW:   sig_low_reg  <= cfg_data;
                CFG_SIG_HIGH:  sig_high_reg <= cfg_data;
                CFG_WILD_MASK: wild_reg     <= cfg_data[SIG_SLOTS-1:0];
                CFG_SIG_LEN:   len_reg      <= cfg_data[SIG_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A length of zero acts as one; a length beyond the window acts as the
    // full window.
    logic [LEN_W-1:0] used_len;
    always_comb begin
        if (len_reg == '0) begin
            used_len = LEN_W'(1);
        end else if (int'(len_reg) > MAX_SIG_LEN) begin
            used_len = LEN_W'(MAX_SIG_LEN);
        end else begin
            used_len = LEN_W'(len_reg);
        end
    end

    sig_cfg_t sig_cfg;
    assign sig_cfg.bytes = {sig_high_reg, sig_low_reg};
    assign sig_cfg.wild  = wild_reg;

    // Handshake and pipeline control. Stage one is the window itself plus the
    // byte count and end-of-image flag of the newest byte; the output register
    // follows. Stage one drains whenever the output register can take a result,
    // whether or not the byte produces one.
    logic s_accept;
    logic out_free;
    logic s1_fire;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_last_reg;
    logic [OFFSET_BITS-1:0] s1_count_reg;

    assign out_free = !m_tvalid || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign s1_fire  = s1_valid_reg && out_free;

    // Byte count of the current image, saturating at its maximum and cleared
    // after the image's last byte.
    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_inc;
    logic [OFFSET_BITS-1:0] count_next;

    always_comb begin
        count_inc  = (count_reg == '1) ? count_reg : count_reg + OFFSET_BITS'(1);
        count_next = count_reg;
        if (s_accept) begin
            count_next = s_tlast ? '0 : count_inc;
        end
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_count_reg <= count_inc;
            s1_last_reg  <= s_tlast;
        end
    end

    // Row of window cells: cell 0 takes the newest byte, each cell hands its
    // byte to the next one on every accepted item.
    logic [MAX_SIG_LEN-1:0][7:0] win_chain;
    logic [MAX_SIG_LEN-1:0]      cell_match;

    for (genvar w = 0; w < MAX_SIG_LEN; w++) begin : g_cell
        wbss_cell #(
            .IDX         (w),
            .MAX_SIG_LEN (MAX_SIG_LEN)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (s_accept),
            .win_in   ((w == 0) ? s_tdata : win_chain[(w == 0) ? 0 : w - 1]),
            .sig_cfg  (sig_cfg),
            .used_len (used_len),
            .win_out  (win_chain[w]),
            .match    (cell_match[w])
        );
    end

    // Match decision. Cells beyond the signature length report a match, so
    // the AND over the row covers exactly the used positions. Entries are only
    // trusted once the image holds at least a full signature.
    logic                   reported_reg;
    logic                   reported_next;
    logic                   hit;
    logic                   emit;
    logic [OFFSET_BITS-1:0] start_pos;

    always_comb begin
        hit       = !reported_reg && (s1_count_reg >= OFFSET_BITS'(used_len))
                    && (&cell_match);
        emit      = hit || (s1_last_reg && !reported_reg);
        start_pos = s1_count_reg - OFFSET_BITS'(used_len);
        reported_next = reported_reg;
        if (s1_fire) begin
            reported_next = s1_last_reg ? 1'b0 : (reported_reg || hit);
        end
    end

    // Output register.
    logic                 m_valid_reg;
    logic                 found_reg;
    logic [OUT_OFF_W-1:0] offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reported_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            reported_reg <= reported_next;
            if (s1_fire && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && emit) begin
            found_reg  <= hit;
            offset_reg <= hit ? OUT_OFF_W'(start_pos) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = offset_reg;

`ifndef SYNTHESIS
    // The reported flag is cleared by every end of image.
    a_reported_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_last_reg) |=> !reported_reg)
        else $error("reported flag survived the end of an image");

    // A not-found result carries a zero offset.
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not-found result with nonzero offset");

    // A byte that does not end the image leaves a nonzero count behind.
    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_tlast) |=> (count_reg != '0))
        else $error("byte count lost within an image");

    // A found result is only produced while nothing was reported yet.
    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && hit) |-> !reported_reg)
        else $error("second match reported within one image");
`endif

endmodule

`default_nettype wire

/* sim/wbss_scan_checker.sv */
`timescale 1ns / 1ps
// Result checker for the wildcard byte signature scanner.
// It follows register writes and image bytes, predicts each result and compares
// it with the result stream. Depends on wbss_pkg.
module wbss_scan_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [wbss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wbss_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [wbss_pkg::OUT_OFF_W-1:0] m_tdata,
    input  logic                           m_tuser,
    output int                             errors,
    output int                             pending,
    output int                             bytes_seen,
    output int                             images_seen,
    output int                             found_seen,
    output int                             missing_seen
);
    import wbss_pkg::*;

    typedef struct packed {
        logic                 found;
        logic [OUT_OFF_W-1:0] offset;
    } scan_result_t;

    scan_result_t results_due[$];

    logic [2*CFG_DAT_W-1:0] pattern;
    logic [SIG_SLOTS-1:0]   wild;
    logic [SIG_LEN_W-1:0]   sig_len;
    logic [BYTE_W-1:0]      window [SIG_SLOTS];
    logic [OUT_OFF_W-1:0]   byte_count;
    logic                   reported;

    int fail_count = 0;
    int due_count  = 0;
    int bytes_n    = 0;
    int images_n   = 0;
    int found_n    = 0;
    int missing_n  = 0;

    assign errors       = fail_count;
    assign pending      = due_count;
    assign bytes_seen   = bytes_n;
    assign images_seen  = images_n;
    assign found_seen   = found_n;
    assign missing_seen = missing_n;

    // Shift one byte into the window and queue the result it causes, if any.
    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
        int           span;
        int           i;
        int           k;
        logic         hit;
        scan_result_t r;
        if (sig_len == 0)
            span = 1;
        else if (sig_len > SIG_SLOTS)
            span = SIG_SLOTS;
        else
            span = int'(sig_len);
        for (i = SIG_SLOTS - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = b;
        if (byte_count != '1)
            byte_count++;
        if (!reported && byte_count >= OUT_OFF_W'(span)) begin
            hit = 1'b1;
            for (k = 0; k < span; k++)
                if (!wild[k] && window[span-1-k] != pattern[8*k +: 8])
                    hit = 1'b0;
            if (hit) begin
                r.found  = 1'b1;
                r.offset = byte_count - OUT_OFF_W'(span);
                results_due = {results_due, r};
                reported = 1'b1;
                found_n++;
            end
        end
        if (last) begin
            if (!reported) begin
                r.found  = 1'b0;
                r.offset = '0;
                results_due = {results_due, r};
                missing_n++;
            end
            byte_count = '0;
            reported   = 1'b0;
            images_n++;
        end
        bytes_n++;
    endtask

    always @(posedge aclk) begin : sample
        scan_result_t due;
        if (!aresetn) begin
            pattern    = '0;
            wild       = '0;
            sig_len    = SIG_LEN_W'(1);
            byte_count = '0;
            reported   = 1'b0;
            foreach (window[i])
                window[i] = '0;
            results_due.delete();
        end else begin
            // A result leaving now stems from a byte taken at an earlier edge.
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: match_found %0d, match_offset %0d",
                           m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    due = results_due.pop_front();
                    if (m_tuser !== due.found) begin
                        $error("match_found mismatch: expected %0d, actual %0d",
                               due.found, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== due.offset) begin
                        $error("match_offset mismatch: expected %0d, actual %0d",
                               due.offset, m_tdata);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SIG_LOW:   pattern[CFG_DAT_W-1:0] = cfg_data;
                    CFG_SIG_HIGH:  pattern[2*CFG_DAT_W-1:CFG_DAT_W] = cfg_data;
                    CFG_WILD_MASK: wild = cfg_data[SIG_SLOTS-1:0];
                    CFG_SIG_LEN:   sig_len = cfg_data[SIG_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                scan_byte(s_tdata, s_tlast);
        end
        due_count = results_due.size();
    end

endmodule

/* sim/wildcard_byte_signature_scan_top_test.sv */
`timescale 1ns / 1ps
// Testbench top for the wildcard byte signature scanner: clock, reset, register
// and image stimulus, result back-pressure and the verdict.
// Depends on wbss_pkg, wildcard_byte_signature_scan_top and wbss_scan_checker.
module wildcard_byte_signature_scan_top_test;
    import wbss_pkg::*;

    // The limit leaves ample room above the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;
    // Long hold-off on the result side, long enough to back the block up.
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_BYTES = 210;

    typedef enum int {IMG_PLANTED, IMG_NEAR_MISS, IMG_NOISE, IMG_SHORT} image_kind_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index = CFG_SIG_LOW;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_OFF_W-1:0] m_tdata;
    logic                 m_tuser;

    int errors;
    int pending;
    int bytes_seen;
    int images_seen;
    int found_seen;
    int missing_seen;
    int cycles = 0;
    int settings_used = 0;

    // Pacing controls for the sender and the receiver process.
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;
    logic rx_hold_req = 1'b0;

    // The setting currently loaded, kept only to shape images that hit or miss.
    logic [2*CFG_DAT_W-1:0] cur_pattern = '0;
    logic [SIG_SLOTS-1:0]   cur_wild = '0;
    logic [SIG_LEN_W-1:0]   cur_len = SIG_LEN_W'(1);

    logic [7:0] image_q[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    wildcard_byte_signature_scan_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] image_byte
        .s_tlast   (s_tlast),   // image_last
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [31:0] match_offset
        .m_tuser   (m_tuser)    // match_found
    );

    wbss_scan_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .errors       (errors),
        .pending      (pending),
        .bytes_seen   (bytes_seen),
        .images_seen  (images_seen),
        .found_seen   (found_seen),
        .missing_seen (missing_seen)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side. Before each result it may stall at random, unless the
    // phase runs without gaps. On request it holds m_tready low for a long
    // stretch that it counts itself, while the sender keeps offering bytes.
    initial begin : receiver
        int stall;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_tready = 1'b0;
                rx_hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = rx_burst ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
        end
    end

    // All driving tasks start and end just after a falling edge.

    function automatic int eff_len(input logic [SIG_LEN_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > SIG_SLOTS)
            return SIG_SLOTS;
        return int'(len);
    endfunction

    // Half the filler is random, half is taken from the signature itself so
    // that partial and overlapping matches show up often.
    function automatic logic [7:0] fill_byte();
        int pos;
        pos = $urandom_range(0, SIG_SLOTS - 1);
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom);
        return cur_pattern[8*pos +: 8];
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Loads all four registers. Bits above the mask and the length fields
    // carry random junk, which the block has to ignore.
    task automatic load_setting(input logic [2*CFG_DAT_W-1:0] pattern,
                                input logic [SIG_SLOTS-1:0] wild,
                                input logic [SIG_LEN_W-1:0] len);
        logic [CFG_DAT_W-1:0] junk;
        junk = {$urandom, $urandom};
        cur_pattern = pattern;
        cur_wild    = wild;
        cur_len     = len;
        write_reg(CFG_SIG_LOW, pattern[CFG_DAT_W-1:0]);
        write_reg(CFG_SIG_HIGH, pattern[2*CFG_DAT_W-1:CFG_DAT_W]);
        write_reg(CFG_WILD_MASK, {junk[CFG_DAT_W-1:SIG_SLOTS], wild});
        write_reg(CFG_SIG_LEN, {junk[CFG_DAT_W-1:SIG_LEN_W], len});
        settings_used++;
    endtask

    // Stop offering bytes and wait until every expected result has been taken.
    // The extra cycles cover a byte that causes no result but is still in flight.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        wait (pending == 0);
        @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Sends the composed image; close selects whether its final byte ends it.
    task automatic send_image(input logic close);
        int i;
        for (i = 0; i < image_q.size(); i++)
            send_byte(image_q[i], close && (i == image_q.size() - 1));
    endtask

    // Most images carry the signature (random bytes at wildcards), some carry it
    // with one byte broken unless wild, the rest are noise or at most its length.
    task automatic compose_image();
        image_kind_t kind;
        int          span;
        int          draw;
        int          k;
        int          flip;
        image_q.delete();
        span = eff_len(cur_len);
        draw = $urandom_range(0, 9);
        if (draw < 6)
            kind = IMG_PLANTED;
        else if (draw < 8)
            kind = IMG_NEAR_MISS;
        else if (draw < 9)
            kind = IMG_NOISE;
        else
            kind = IMG_SHORT;
        case (kind)
            IMG_NOISE: begin
                repeat ($urandom_range(1, 30)) image_q = {image_q, 8'($urandom)};
            end
            IMG_SHORT: begin
                repeat ($urandom_range(1, span)) image_q = {image_q, fill_byte()};
            end
            default: begin
                repeat ($urandom_range(0, 12)) image_q = {image_q, fill_byte()};
                for (k = 0; k < span; k++)
                    image_q = {image_q,
                               cur_wild[k] ? 8'($urandom) : cur_pattern[8*k +: 8]};
                if (kind == IMG_NEAR_MISS) begin
                    flip = $urandom_range(0, span - 1);
                    if (!cur_wild[flip])
                        image_q[image_q.size() - span + flip] ^= 8'($urandom_range(1, 255));
                end
                // A third of the images end right on the signature's last byte.
                if ($urandom_range(0, 2) != 0)
                    repeat ($urandom_range(1, 8)) image_q = {image_q, fill_byte()};
            end
        endcase
    endtask

    initial begin : stimulus
        int                     phase;
        int                     phase_bytes;
        logic                   paused;
        logic [2*CFG_DAT_W-1:0] pattern;
        logic [SIG_SLOTS-1:0]   wild;
        logic [SIG_LEN_W-1:0]   len;

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part. Out of reset the signature is the single byte 00, so
        // the match completes on the last byte and no not-found may follow.
        image_q = '{8'hFF, 8'h00};
        send_image(1'b1);
        wait_idle();

        // Three bytes A5, any, 00; the upper register is all ones.
        load_setting({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FF00_FFA5},
                     16'hFFFA, 5'd3);
        // An image shorter than the signature has no candidate at all.
        image_q = '{8'hA5};
        send_image(1'b1);
        // Match at offset 0; the second match at offset 3 must be ignored.
        image_q = '{8'hA5, 8'h3C, 8'h00, 8'hA5, 8'h77, 8'h00};
        send_image(1'b1);

        // Length change in the middle of an image: a length of zero acts as
        // one, so the following A5 matches at offset 2.
        image_q = '{8'h11, 8'hA5};
        send_image(1'b0);
        wait_idle();
        write_reg(CFG_SIG_LEN, 64'h0);
        cur_len = '0;
        image_q = '{8'hA5};
        send_image(1'b1);
        wait_idle();

        // A length above sixteen acts as sixteen; all positions are wildcards.
        load_setting('0, 16'hFFFF, 5'd31);
        image_q.delete();
        repeat (8) begin
            image_q = {image_q, 8'h00};
            image_q = {image_q, 8'hFF};
        end
        send_image(1'b1);

        // Random part, one register setting per phase, extremes first.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            pattern = {$urandom, $urandom, $urandom, $urandom};
            wild    = SIG_SLOTS'($urandom & $urandom);
            len     = SIG_LEN_W'($urandom_range(2, 15));
            case (phase)
                0: begin
                    pattern = '0;
                    wild    = '0;
                    len     = SIG_LEN_W'(1);
                end
                1: begin
                    pattern = '1;
                    len     = SIG_LEN_W'(SIG_SLOTS);
                end
                2: wild = '1;
                3: len = '0;
                4: len = '1;
                5: len = SIG_LEN_W'($urandom_range(SIG_SLOTS + 1, 30));
                default: ;
            endcase
            load_setting(pattern, wild, len);
            rx_burst = ($urandom_range(0, 3) == 0);
            // Back the block up once: the receiver stalls while bytes keep coming.
            if (phase == 3)
                rx_hold_req = 1'b1;
            phase_bytes = 0;
            paused = 1'b0;
            while (phase_bytes < PHASE_BYTES) begin
                // Once, the sender drains everything in the middle of a phase.
                if (phase == 5 && !paused && phase_bytes >= PHASE_BYTES / 2) begin
                    wait_idle();
                    paused = 1'b1;
                end
                compose_image();
                tx_burst = ($urandom_range(0, 4) == 0);
                send_image(1'b1);
                phase_bytes += image_q.size();
            end
        end
        s_tvalid = 1'b0;

        // Drain, then watch a while longer for results nobody asked for.
        wait (pending == 0);
        repeat (10) @(posedge aclk);

        $display("Scanned %0d image bytes in %0d images under %0d register settings.",
                 bytes_seen, images_seen, settings_used);
        $display("Signatures located in %0d images, %0d images ended without one.",
                 found_seen, missing_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* wildcard_byte_signature_scan_top.f */
rtl/core/wbss_pkg.sv
rtl/core/wbss_cell.sv
rtl/core/wildcard_byte_signature_scan_top.sv
sim/wbss_scan_checker.sv
sim/wildcard_byte_signature_scan_top_test.sv
